// File: design/rstal_pkg.sv
// Shared types and constants for the recursive STA/LTA detector.
package rstal_pkg;

    localparam int AVG_BITS     = 64;
    localparam int RATIO_BITS   = 32;
    localparam int SHORT_W_BITS = 16;
    localparam int LONG_W_BITS  = 20;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = LONG_W_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_WINDOW = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_WINDOW  = 1'd1;

    localparam logic [SHORT_W_BITS-1:0] SHORT_W_RESET = 16'd40;
    localparam logic [LONG_W_BITS-1:0]  LONG_W_RESET  = 20'd400;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_TARGET,
        S_SHORT_GO,
        S_SHORT_WAIT,
        S_LONG_GO,
        S_LONG_WAIT,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

// File: design/rstal_in_if.sv
// Request channel carrying one sample and its restart flag.
interface rstal_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

// File: design/rstal_out_if.sv
// Result channel carrying the STA/LTA ratio and the warm-up flag.
interface rstal_out_if;
    logic                            valid;
    logic                            ready;
    logic [rstal_pkg::RATIO_BITS-1:0] ratio;
    logic                            warmed;

    modport source (output valid, output ratio, output warmed, input ready);
    modport sink   (input valid, input ratio, input warmed, output ready);
endinterface

// File: design/rstal_div.sv
// Restoring serial divider, one quotient bit per cycle.
module rstal_div #(
    parameter int DW = 80,
    parameter int VW = 64,
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CW-1:0]        i_cycles,
    input  logic [DW-1:0]        i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic [DW-1:0]        o_quot,
    output rstal_pkg::t_div_stat o_stat
);
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quot[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = !w_diff[VW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= i_cycles;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when the divisor fits
            r_quot <= {r_quot[DW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    assign o_quot        = r_quot;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = (r_rem != '0);
endmodule

// File: design/recursive_sta_lta_detector_unit.sv
// Recursive STA/LTA detector: top level with sequencer, serial squarer and averages.
//
// Usage: each request on i_in carries one signed sample and a restart flag; each
// one yields exactly one result on o_out: the short/long energy ratio in
// unsigned fixed point with FRAC_BITS fraction bits, and the warmed flag.
// Both channels use valid/ready; a request is taken when both are high.
// Windows are written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// One request is processed at a time. Each passes through the shift-add squarer
// and three passes through the one-bit-per-cycle divider (short average, long
// average, ratio); during warm-up the ratio pass is skipped.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result holds in the finish state until the register frees.
// Reset restores windows 40 and 400, clears the short average, seeds the long
// average to one LSB and clears the sample count; restart does the same for
// the averages and the count only.
module recursive_sta_lta_detector_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rstal_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rstal_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    rstal_in_if.sink                           i_in,
    rstal_out_if.source                        o_out
);
    localparam int AB  = rstal_pkg::AVG_BITS;
    localparam int RB  = rstal_pkg::RATIO_BITS;
    localparam int SB  = rstal_pkg::SHORT_W_BITS;
    localparam int LB  = rstal_pkg::LONG_W_BITS;
    localparam int PB  = 2 * SAMPLE_BITS;
    localparam int DW  = AB + FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);
    localparam int MCW = $clog2(SAMPLE_BITS + 1);
    localparam logic [AB-1:0] SQ_MAX = (AB'(1) << (AB - FRAC_BITS)) - AB'(1);

    rstal_pkg::t_state r_state, n_state;

    logic [SB-1:0]          r_short_w;
    logic [LB-1:0]          r_long_w;
    logic [AB-1:0]          r_short_avg;
    logic [AB-1:0]          r_long_avg;
    logic [LB-1:0]          r_seen;
    logic                   r_warm;
    logic [PB-1:0]          r_acc;
    logic [PB-1:0]          r_mcand;
    logic [SAMPLE_BITS-1:0] r_mplier;
    logic [MCW-1:0]         r_mcnt;
    logic [AB-1:0]          r_target;
    logic                   r_ge;
    logic [RB-1:0]          r_res;
    logic                   r_out_valid;
    logic [RB-1:0]          r_ratio;
    logic                   r_warmed;

    logic                   w_accept;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [LB-1:0]          w_lw;
    logic [LB-1:0]          w_seen_cur;
    logic [AB-1:0]          w_sq;
    logic [AB-1:0]          w_avg_sel;
    logic                   w_ge;
    logic [AB-1:0]          w_diff;
    logic [AB-1:0]          w_q;
    logic [AB-1:0]          w_avg_new;
    logic [AB-1:0]          w_den;
    logic                   w_out_load;

    logic                   div_start;
    logic [CW-1:0]          div_cycles;
    logic [DW-1:0]          div_dividend;
    logic [AB-1:0]          div_divisor;
    logic [DW-1:0]          div_quot;
    rstal_pkg::t_div_stat   div_stat;

    rstal_div #(
        .DW (DW),
        .VW (AB),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_cycles   (div_cycles),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_mag      = i_in.sample[SAMPLE_BITS-1] ? (~i_in.sample + SAMPLE_BITS'(1))
                                                   : i_in.sample;
    assign w_lw       = (r_long_w == '0) ? LB'(1) : r_long_w;
    assign w_seen_cur = i_in.restart ? '0 : r_seen;
    assign w_sq       = (AB'(r_acc) > SQ_MAX) ? SQ_MAX : AB'(r_acc);

    // shared difference and update for whichever average is in flight
    always_comb begin
        w_avg_sel = (r_state == rstal_pkg::S_SHORT_GO || r_state == rstal_pkg::S_SHORT_WAIT)
                    ? r_short_avg : r_long_avg;
        w_ge      = (r_target >= w_avg_sel);
        w_diff    = w_ge ? (r_target - w_avg_sel) : (w_avg_sel - r_target);
        w_q       = div_quot[AB-1:0];
        w_avg_new = r_ge ? (w_avg_sel + w_q)
                         : (w_avg_sel - w_q - (div_stat.rem_nz ? AB'(1) : AB'(0)));
        w_den     = (r_long_avg == '0) ? AB'(1) : r_long_avg;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_w <= rstal_pkg::SHORT_W_RESET;
            r_long_w  <= rstal_pkg::LONG_W_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rstal_pkg::CFG_SHORT_WINDOW: r_short_w <= i_cfg_data[SB-1:0];
                rstal_pkg::CFG_LONG_WINDOW:  r_long_w  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rstal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_in.ready   = 1'b0;
        div_start    = 1'b0;
        div_cycles   = CW'(AB);
        div_dividend = {w_diff, FRAC_BITS'(0)};
        div_divisor  = '0;
        w_out_load   = 1'b0;
        unique case (r_state)
            rstal_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) n_state = rstal_pkg::S_SQUARE;
            end
            rstal_pkg::S_SQUARE: begin
                if (r_mcnt == MCW'(1)) n_state = rstal_pkg::S_TARGET;
            end
            rstal_pkg::S_TARGET: begin
                n_state = rstal_pkg::S_SHORT_GO;
            end
            rstal_pkg::S_SHORT_GO: begin
                div_start   = 1'b1;
                div_divisor = (r_short_w == '0) ? AB'(1) : AB'(r_short_w);
                n_state     = rstal_pkg::S_SHORT_WAIT;
            end
            rstal_pkg::S_SHORT_WAIT: begin
                if (div_stat.done) n_state = rstal_pkg::S_LONG_GO;
            end
            rstal_pkg::S_LONG_GO: begin
                div_start   = 1'b1;
                div_divisor = AB'(w_lw);
                n_state     = rstal_pkg::S_LONG_WAIT;
            end
            rstal_pkg::S_LONG_WAIT: begin
                if (div_stat.done) begin
                    n_state = r_warm ? rstal_pkg::S_RATIO_GO : rstal_pkg::S_FINISH;
                end
            end
            rstal_pkg::S_RATIO_GO: begin
                div_start    = 1'b1;
                div_cycles   = CW'(DW);
                div_dividend = {r_short_avg, FRAC_BITS'(0)};
                div_divisor  = w_den;
                n_state      = rstal_pkg::S_RATIO_WAIT;
            end
            rstal_pkg::S_RATIO_WAIT: begin
                if (div_stat.done) n_state = rstal_pkg::S_FINISH;
            end
            rstal_pkg::S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = rstal_pkg::S_IDLE;
                end
            end
            default: n_state = rstal_pkg::S_IDLE;
        endcase
    end

    // averages and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_avg <= '0;
            r_long_avg  <= AB'(1);
            r_seen      <= '0;
        end else begin
            if (w_accept) begin
                if (i_in.restart) begin
                    r_short_avg <= '0;
                    r_long_avg  <= AB'(1);
                end
                if (w_seen_cur < w_lw) begin
                    r_seen <= w_seen_cur + LB'(1);
                end else begin
                    r_seen <= w_seen_cur;
                end
            end
            if (r_state == rstal_pkg::S_SHORT_WAIT && div_stat.done) r_short_avg <= w_avg_new;
            if (r_state == rstal_pkg::S_LONG_WAIT && div_stat.done)  r_long_avg  <= w_avg_new;
        end
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_warm   <= (w_seen_cur >= w_lw);
            r_acc    <= '0;
            r_mcand  <= PB'(w_mag);
            r_mplier <= w_mag;
            r_mcnt   <= MCW'(SAMPLE_BITS);
            r_res    <= '0;
        end
        if (r_state == rstal_pkg::S_SQUARE) begin
            if (r_mplier[0]) r_acc <= r_acc + r_mcand;
            r_mcand  <= {r_mcand[PB-2:0], 1'b0};
            r_mplier <= r_mplier >> 1;
            r_mcnt   <= r_mcnt - MCW'(1);
        end
        if (r_state == rstal_pkg::S_TARGET) begin
            r_target <= w_sq << FRAC_BITS;
        end
        if (r_state == rstal_pkg::S_SHORT_GO || r_state == rstal_pkg::S_LONG_GO) begin
            r_ge <= w_ge;
        end
        if (r_state == rstal_pkg::S_RATIO_WAIT && div_stat.done) begin
            r_res <= (div_quot[DW-1:RB] != '0) ? '1 : div_quot[RB-1:0];
        end
        if (w_out_load) begin
            r_ratio  <= r_res;
            r_warmed <= r_warm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.ratio  = r_ratio;
    assign o_out.warmed = r_warmed;

    a_accept_starts_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == rstal_pkg::S_SQUARE)
        else $error("accepted request did not start the squarer");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == rstal_pkg::S_SHORT_WAIT ||
                           r_state == rstal_pkg::S_LONG_WAIT ||
                           r_state == rstal_pkg::S_RATIO_WAIT))
        else $error("divider finished outside a wait state");

    a_cold_ratio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.warmed) |-> o_out.ratio == '0)
        else $error("nonzero ratio during warm-up");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !w_out_load)
        else $error("result overwritten while stalled");
endmodule
